// File: rtl/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types, constants and hash functions for the linear probe hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = 31;
  localparam int CNT_W       = 10;
  localparam int STATUS_W    = 2;
  localparam int HASH_W      = 32;

  // mixer multiplier
  localparam logic [HASH_W-1:0] MIX_MULT = 32'h045d_9f3b;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISS     = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // request opcodes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_SEED,
    S_CHECK,
    S_RESULT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_we;    // write one valid-map entry of the clearing pass
    logic load_in;   // capture request and run first mixer round
    logic seed;      // second mixer round, home bucket into probe index
    logic rd_seed;   // read slot at probe index
    logic rd_next;   // read slot after probe index
    logic step;      // advance probe index and count
    logic finish;    // resolve the request, insert if due
    logic out_load;  // move result into output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;    // clearing pass at last entry
    logic hit;         // probed slot holds the key
    logic empty;       // probed slot is empty
    logic probe_last;  // every slot has been probed
    logic out_free;    // output register can take a word this cycle
  } sts_t;

  // one xor-shift and multiply round, modulo 2^32
  function automatic logic [HASH_W-1:0] mix_step(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] x;
    x = h ^ (h >> 16);
    return x * MIX_MULT;
  endfunction

  // final xor-shift, masked to a bucket
  function automatic logic [SLOT_W-1:0] bucket_of(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] x;
    x = h ^ (h >> 16);
    return x[SLOT_W-1:0];
  endfunction

endpackage

// File: rtl/lph_ram.sv
// ----------------------------------------------------------------------------
// lph_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lph_ctrl.sv
// ----------------------------------------------------------------------------
// lph_ctrl
// Sequencer for the hash table: clearing pass, hashing, probe loop, result.
// ----------------------------------------------------------------------------
module lph_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  lph_pkg::sts_t sts,
  output logic          in_stall,
  output lph_pkg::cmd_t cmd
);

  import lph_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   resolved;

  // probe ends on hit, empty slot or full wrap
  assign resolved = sts.hit || sts.empty || sts.probe_last;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_HASH;
      end
      S_HASH: begin
        state_nxt = S_SEED;
      end
      S_SEED: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (resolved) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_HASH: begin
        cmd.seed = 1'b1;
      end
      S_SEED: begin
        cmd.rd_seed = 1'b1;
      end
      S_CHECK: begin
        // next slot is read ahead while this one is checked
        cmd.finish  = resolved;
        cmd.step    = !resolved;
        cmd.rd_next = !resolved;
      end
      S_RESULT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/lph_dpath.sv
// ----------------------------------------------------------------------------
// lph_dpath
// Datapath: request registers, mixer, probe index, slot memories, entry count,
// limit register and output register.
// ----------------------------------------------------------------------------
module lph_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lph_pkg::cmd_t                 cmd,
  output lph_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [lph_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_opcode,
  input  logic [lph_pkg::KEY_W-1:0]     in_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lph_pkg::STATUS_W-1:0]  out_status,
  output logic [lph_pkg::SLOT_W-1:0]    out_slot,
  output logic [lph_pkg::CNT_W-1:0]     out_entry_total
);

  import lph_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_DEPTH - 1);

  // request and probe registers
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [HASH_W-1:0] mix_r;
  logic [SLOT_W-1:0] idx_r;
  logic [SLOT_W-1:0] probe_r;
  logic [SLOT_W-1:0] clr_cnt_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  max_r;
  status_t           res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [CNT_W-1:0]  out_total_r;

  // memory ports
  logic              ram_we;
  logic              key_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic              valid_q;
  logic [KEY_W-1:0]  key_q;
  logic [SLOT_W-1:0] idx_inc;

  logic              hit;
  logic              empty;
  logic              do_insert;
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;

  assign idx_inc = idx_r + 1'b1;

  // probe outcome for the slot read last cycle
  assign empty     = !valid_q;
  assign hit       = valid_q && (key_q == key_r);
  assign do_insert = (op_r == OP_INSERT) && !hit && empty && (count_r < max_r);

  // status to controller
  assign sts.clr_last   = (clr_cnt_r == SLOT_LAST);
  assign sts.hit        = hit;
  assign sts.empty      = empty;
  assign sts.probe_last = (probe_r == SLOT_LAST);
  assign sts.out_free   = !out_valid_r || !out_stall;

  // memory address and enables
  assign ram_we    = cmd.clr_we || (cmd.finish && do_insert);
  assign key_we    = cmd.finish && do_insert;
  assign ram_waddr = cmd.clr_we ? clr_cnt_r : idx_r;
  assign ram_re    = cmd.rd_seed || cmd.rd_next;
  assign ram_raddr = cmd.rd_next ? idx_inc : idx_r;

  // valid map, cleared by the pass after reset
  lph_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_DEPTH)
  ) u_valid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (!cmd.clr_we),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (valid_q)
  );

  // stored keys, read only behind a set valid bit
  lph_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (idx_r),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (key_q)
  );

  // request capture and mixer rounds
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_opcode;
      key_r <= in_key;
      mix_r <= mix_step({1'b0, in_key});
    end
  end

  // probe index and probe count
  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      idx_r   <= bucket_of(mix_step(mix_r));
      probe_r <= '0;
    end else if (cmd.step) begin
      idx_r   <= idx_inc;
      probe_r <= probe_r + 1'b1;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= CNT_W'(768);
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.finish && do_insert) begin
      count_r <= count_r + 1'b1;
    end
  end

  // resolve request
  always_comb begin
    res_slot = '0;
    priority if (hit) begin
      res_status = ST_FOUND;
      res_slot   = idx_r;
    end else if (op_r == OP_LOOKUP) begin
      res_status = ST_MISS;
    end else if (do_insert) begin
      res_status = ST_INSERTED;
      res_slot   = idx_r;
    end else begin
      res_status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status_r <= res_status;
      res_slot_r   <= res_slot;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_total_r  <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_entry_total = out_total_r;

endmodule

// File: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing over 31-bit keys. Looks up
// or inserts a key and returns its slot, a miss or a full refusal.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  in       | in_valid, in_stall, in_opcode, in_key        | request in
//  out      | out_valid, out_stall, out_status, out_slot,  | result out
//           | out_entry_total                              |
//  cfg      | cfg_we, cfg_wdata (max_entries)              | write only
//
// Two mixer multiplies run one per cycle, the first as the request is taken,
// then the probe loop reads one slot a cycle, 1 to 1024 slots, until a hit, an
// empty slot or a full wrap. out_valid rises as the result enters the output
// register; only then is the next request taken. After reset a clearing pass
// empties the valid map with in_stall high. A finished word waits in the output
// register while the next request is taken; a new result waits for it to free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [lph_pkg::KEY_W-1:0]     in_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lph_pkg::STATUS_W-1:0]  out_status,
  output logic [lph_pkg::SLOT_W-1:0]    out_slot,
  output logic [lph_pkg::CNT_W-1:0]     out_entry_total,
  input  logic                          cfg_we,
  input  logic [lph_pkg::CNT_W-1:0]     cfg_wdata
);

  import lph_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  lph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // datapath
  lph_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_entry_total (out_entry_total)
  );

endmodule

// File: tb/sv/linear_probe_hash_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Self-checking bench for the linear probe hash table. A scoreboard keeps its
// own copy of the table, predicts status, slot and entry total for every
// accepted request word, and checks each result word in order. Directed
// requests cover the zero and unit limits, updates at the limit, extreme keys
// and probe wraparound. Random phases under several limits and idle patterns
// follow, then the table is filled to its largest limit and probed while full.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_test;
  import lph_pkg::*;

  // expected result word
  typedef struct {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [CNT_W-1:0]   total;
  } result_word_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // table shadow and expected result words
  class hash_table_board;
    bit                 used_map [TABLE_DEPTH];
    logic [KEY_W-1:0]   key_map  [TABLE_DEPTH];
    logic [CNT_W-1:0]   stored;
    logic [CNT_W-1:0]   max_entries;
    result_word_t       expected_words [$];
    int                 errors;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      stored      = '0;
      max_entries = 10'd768;
      errors      = 0;
    endfunction

    // xor-shift and multiply mixer, low bits give the home bucket
    static function logic [SLOT_W-1:0] home_of(logic [KEY_W-1:0] key);
      logic [31:0] h;
      h = {1'b0, key};
      h = (h ^ (h >> 16)) * MIX_MULT;
      h = (h ^ (h >> 16)) * MIX_MULT;
      h = h ^ (h >> 16);
      return h[SLOT_W-1:0];
    endfunction

    function void set_limit(logic [CNT_W-1:0] value);
      max_entries = value;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // walk the probe sequence and resolve one request word
    function void predict_request(logic op, logic [KEY_W-1:0] key);
      logic [SLOT_W-1:0] idx;
      bit                hit;
      bit                empty;
      int                n;
      result_word_t      w;
      idx   = home_of(key);
      hit   = 1'b0;
      empty = 1'b0;
      n     = 0;
      while (n < TABLE_DEPTH && !hit && !empty) begin
        if (!used_map[idx]) begin
          empty = 1'b1;
        end else if (key_map[idx] == key) begin
          hit = 1'b1;
        end else begin
          idx = idx + 1'b1;
          n++;
        end
      end
      w.slot = '0;
      if (hit) begin
        w.status = ST_FOUND;
        w.slot   = idx;
      end else if (op == OP_LOOKUP) begin
        w.status = ST_MISS;
      end else if (empty && stored < max_entries) begin
        used_map[idx] = 1'b1;
        key_map[idx]  = key;
        stored        = stored + 1'b1;
        w.status      = ST_INSERTED;
        w.slot        = idx;
      end else begin
        w.status = ST_FULL;
      end
      w.total = stored;
      expected_words.push_back(w);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    // compare one result word with the oldest expectation
    function void check_word(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                             logic [CNT_W-1:0] total);
      result_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual status %0d slot %0d total %0d",
                 $time, status, slot, total);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      compare_field("status", w.status, status);
      compare_field("slot", w.slot, slot);
      compare_field("entry_total", w.total, total);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_opcode = OP_LOOKUP;
  logic [KEY_W-1:0]     in_key = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [SLOT_W-1:0]    out_slot;
  logic [CNT_W-1:0]     out_entry_total;
  logic                 cfg_we = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata = '0;

  hash_table_board      board = new();
  logic [KEY_W-1:0]     sent_keys [$];
  int unsigned          send_idle_pct = 0;
  int unsigned          stall_pct = 0;

  linear_probe_hash_table i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_entry_total (out_entry_total),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result word monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      board.check_word(out_status, out_slot, out_entry_total);
    end
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 68; stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 68; end
      default:   begin send_idle_pct = 24; stall_pct = 24; end
    endcase
  endtask

  // present one request word and hold it until accepted
  task automatic send_request(logic op, logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_key    <= key;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.predict_request(op, key);
    if (op == OP_INSERT) sent_keys.push_back(key);
    @(negedge clk);
  endtask

  // hold off the sender until every expected word has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_max_entries(logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_limit(value);
  endtask

  // mix of fresh inserts, hits, updates, misses and edge keys
  task automatic send_random_item();
    int unsigned       pick;
    logic [31:0]       rnd;
    logic [KEY_W-1:0]  key;
    logic              op;
    pick = $urandom_range(99);
    rnd  = $urandom();
    if (pick < 45 || sent_keys.size() == 0) begin
      op  = OP_INSERT;
      key = rnd[KEY_W-1:0];
    end else if (pick < 65) begin
      op  = OP_LOOKUP;
      key = sent_keys[$urandom_range(sent_keys.size() - 1)];
    end else if (pick < 80) begin
      op  = OP_INSERT;
      key = sent_keys[$urandom_range(sent_keys.size() - 1)];
    end else if (pick < 92) begin
      op  = OP_LOOKUP;
      key = rnd[KEY_W-1:0];
    end else begin
      op  = rnd[31];
      key = rnd[0] ? {27'h7FF_FFFF, rnd[4:1]} : {27'd0, rnd[4:1]};
    end
    send_request(op, key);
  endtask

  // one limit setting, idle pattern rotating every 12 words
  task automatic run_phase(logic [CNT_W-1:0] limit, int count);
    wait_for_results();
    write_max_entries(limit);
    for (int i = 0; i < count; i++) begin
      set_idle(idle_mode_t'((i / 12) % 4));
      if ($urandom_range(99) == 0) wait_for_results();
      send_random_item();
    end
  endtask

  task automatic run_directed();
    logic [KEY_W-1:0] wrap_keys [$];
    logic [KEY_W-1:0] probe_key;
    // keys whose home bucket is the last slot, so probing wraps round
    probe_key = 31'h0010_0000;
    while (wrap_keys.size() < 3) begin
      if (hash_table_board::home_of(probe_key) == TABLE_DEPTH - 1) begin
        wrap_keys.push_back(probe_key);
      end
      probe_key = probe_key + 1'b1;
    end
    // zero limit refuses every new key
    write_max_entries(10'd0);
    send_request(OP_INSERT, 31'd0);
    send_request(OP_LOOKUP, 31'd0);
    // limit of one: insert, update at the limit, refusal
    wait_for_results();
    write_max_entries(10'd1);
    send_request(OP_INSERT, 31'h7FFF_FFFF);
    send_request(OP_INSERT, 31'h7FFF_FFFF);
    send_request(OP_INSERT, 31'd0);
    send_request(OP_LOOKUP, 31'h7FFF_FFFF);
    send_request(OP_LOOKUP, 31'd0);
    // largest limit: extreme keys and a wrapping probe chain
    wait_for_results();
    write_max_entries(10'd1023);
    send_request(OP_INSERT, 31'd0);
    send_request(OP_INSERT, 31'h5555_5555);
    send_request(OP_INSERT, 31'h2AAA_AAAA);
    send_request(OP_LOOKUP, 31'h5555_5555);
    send_request(OP_LOOKUP, 31'h2AAA_AAAA);
    foreach (wrap_keys[i]) send_request(OP_INSERT, wrap_keys[i]);
    send_request(OP_LOOKUP, wrap_keys[2]);
    send_request(OP_LOOKUP, wrap_keys[0]);
    send_request(OP_INSERT, wrap_keys[1]);
    send_request(OP_LOOKUP, 31'h1234_5678);
  endtask

  // main sequence
  initial begin
    logic [31:0] rnd;
    int          tries;
    set_idle(IDLE_NONE);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    // let the valid map clearing pass finish
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);

    run_directed();

    run_phase(10'd20, 50);
    run_phase(10'd300, 50);
    run_phase(10'd5, 50);
    run_phase(10'd768, 50);
    run_phase(10'($urandom_range(900, 400)), 50);
    run_phase(10'd1023, 50);

    // fill to the largest limit, probe chains grow long
    tries = 0;
    while (board.stored != 10'd1023 && tries < 2000) begin
      set_idle(idle_mode_t'((tries / 50) % 4));
      rnd = $urandom();
      send_request(OP_INSERT, rnd[KEY_W-1:0]);
      tries++;
    end

    // table at its limit: misses probe on to the one empty slot
    set_idle(IDLE_BOTH);
    for (int i = 0; i < 40; i++) send_random_item();

    wait_for_results();
    set_idle(IDLE_NONE);
    repeat (1100) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("linear_probe_hash_table regression: pass");
    end else begin
      $display("linear_probe_hash_table regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #80_000_000;
    $display("linear_probe_hash_table regression: fail");
    $finish;
  end

endmodule
